[rtl/core/sgb_pkg.sv]
// ----------------------------------------------------------------------------
// SipHash edge generator package
// Shared widths, register codes, key and state types and the SipHash
// half-round functions used by the hash lanes and the top level.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned EDGE_IDX_W  = 30;
  localparam int unsigned NODE_W      = 31;
  localparam int unsigned BKT_ID_W    = 5;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned EDGE_BITS_W = 5;
  localparam int unsigned BKT_BITS_W  = 3;

  // Twelve half-rounds: two compression rounds, four final rounds.
  localparam int unsigned HASH_STAGES   = 12;
  // Stage whose output takes the message and finalisation constant.
  localparam int unsigned MSG_XOR_STAGE = 4;

  localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h0000_0000_0000_00ff;

  localparam logic [EDGE_BITS_W-1:0] EDGE_BITS_RST = 5'd20;
  localparam logic [BKT_BITS_W-1:0]  BKT_BITS_RST  = 3'd5;
  localparam logic [CNT_W-1:0]       BKT_CAP_RST   = 32'd33792;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_EDGE_BITS = 3'd4,
    REG_BKT_BITS  = 3'd5,
    REG_BKT_CAP   = 3'd6
  } sgb_reg_e;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } sgb_key_t;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } sgb_state_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // First half of a SipRound: v0 += v1, v2 += v3 and their mixing.
  function automatic sgb_state_t sip_half_a(input sgb_state_t s);
    sgb_state_t r;
    r    = s;
    r.v0 = s.v0 + s.v1;
    r.v2 = s.v2 + s.v3;
    r.v1 = rotl64(s.v1, 13) ^ r.v0;
    r.v3 = rotl64(s.v3, 16) ^ r.v2;
    r.v0 = rotl64(r.v0, 32);
    return r;
  endfunction

  // Second half of a SipRound: v2 += v1, v0 += v3 and their mixing.
  function automatic sgb_state_t sip_half_b(input sgb_state_t s);
    sgb_state_t r;
    r    = s;
    r.v2 = s.v2 + s.v1;
    r.v0 = s.v0 + s.v3;
    r.v1 = rotl64(s.v1, 17) ^ r.v2;
    r.v3 = rotl64(s.v3, 21) ^ r.v0;
    r.v2 = rotl64(r.v2, 32);
    return r;
  endfunction

endpackage

[rtl/core/sgb_sip_pipe.sv]
// ----------------------------------------------------------------------------
// SipHash-2-4 hash lane
// One half-round per stage; the whole lane advances on en_i. Each message
// passes st_q[0] and every half-round stage before its hash shows on hash_o.
// ----------------------------------------------------------------------------
module sgb_sip_pipe (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  sgb_pkg::sgb_key_t         key_i,
  input  logic [sgb_pkg::WORD_W-1:0] msg_i,
  output logic [sgb_pkg::WORD_W-1:0] hash_o
);
  import sgb_pkg::*;

  sgb_state_t        st_q [HASH_STAGES+1];
  sgb_state_t        st_d [HASH_STAGES+1];
  logic [WORD_W-1:0] msg_q [MSG_XOR_STAGE+1];

  always_comb begin
    sgb_state_t pre;
    st_d[0] = '{v0: key_i.k0, v1: key_i.k1, v2: key_i.k2, v3: key_i.k3 ^ msg_i};
    for (int k = 1; k <= HASH_STAGES; k++) begin
      pre = st_q[k-1];
      if (k - 1 == MSG_XOR_STAGE) begin
        pre.v0 = pre.v0 ^ msg_q[MSG_XOR_STAGE];
        pre.v2 = pre.v2 ^ SIP_FINAL_XOR;
      end
      if (k % 2 == 1) begin
        st_d[k] = sip_half_a(pre);
      end else begin
        st_d[k] = sip_half_b(pre);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= HASH_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
      msg_q[0] <= msg_i;
      for (int k = 1; k <= MSG_XOR_STAGE; k++) begin
        msg_q[k] <= msg_q[k-1];
      end
    end
  end

  assign hash_o = st_q[HASH_STAGES].v0 ^ st_q[HASH_STAGES].v1 ^
                  st_q[HASH_STAGES].v2 ^ st_q[HASH_STAGES].v3;

endmodule

[rtl/core/siphash_edge_generator_bucketer_core.sv]
// ----------------------------------------------------------------------------
// SipHash edge generator and bucketer
// Hashes each edge index into two graph nodes, picks a bucket from the
// first node and hands out a slot from a per-bucket fill counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one edge_index_i per
//   transfer. Output channel: out_valid_o / out_stall_i carry the two nodes,
//   bucket, slot and flags of that edge, in input order, one per transfer.
//   Configuration: write key words, edge_bits, bucket_bits and capacity
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// Throughput: one edge per cycle while in_stall_o is low. Two hash lanes of
//   twelve half-round stages run side by side; the bucket counters sit in a
//   small memory read in the stage before the update, with forwarding
//   between back-to-back edges that hit the same bucket.
// Path: an edge passes the hash lanes, node stage, update stage and output register.
// Reset: configuration returns to its defaults and every bucket counter
//   reads as zero at once through per-bucket valid bits; no clearing pass.
// Stall: a two-entry output buffer (output register plus skid) keeps the
//   pipeline running for one more result after the receiver stalls; the
//   input stalls only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module siphash_edge_generator_bucketer_core #(
  parameter int unsigned BUCKET_BITS_MAX = 5,
  parameter int unsigned EDGE_BITS_MAX   = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sgb_pkg::WORD_W-1:0]    cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sgb_pkg::EDGE_IDX_W-1:0] edge_index_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sgb_pkg::NODE_W-1:0]    node_u_o,
  output logic [sgb_pkg::NODE_W-1:0]    node_v_o,
  output logic [sgb_pkg::BKT_ID_W-1:0]  bucket_id_o,
  output logic [sgb_pkg::CNT_W-1:0]     slot_index_o,
  output logic                          stored_o,
  output logic                          distinct_o,
  output logic                          rejected_o
);
  import sgb_pkg::*;

  // Counter memory geometry. The bucket_bits register never selects more
  // than 2^BKT_BITS_W - 1 bits, so no more buckets than that are addressed.
  localparam int unsigned BKT_REG_MAX = (1 << BKT_BITS_W) - 1;
  localparam int unsigned BKT_AW      = (BUCKET_BITS_MAX < BKT_REG_MAX) ?
                                        BUCKET_BITS_MAX : BKT_REG_MAX;
  localparam int unsigned NB          = 1 << BKT_AW;
  localparam int unsigned AW          = (BKT_AW > 0) ? BKT_AW : 1;

  typedef struct packed {
    logic [NODE_W-1:0]   node_u;
    logic [NODE_W-1:0]   node_v;
    logic [BKT_ID_W-1:0] bucket_id;
    logic [CNT_W-1:0]    slot_index;
    logic                stored;
    logic                distinct;
    logic                rejected;
  } res_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  sgb_key_t               key_q;
  logic [EDGE_BITS_W-1:0] edge_bits_q;
  logic [BKT_BITS_W-1:0]  bkt_bits_q;
  logic [CNT_W-1:0]       bkt_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      edge_bits_q <= EDGE_BITS_RST;
      bkt_bits_q  <= BKT_BITS_RST;
      bkt_cap_q   <= BKT_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY0:      key_q.k0    <= cfg_wdata_i;
        REG_KEY1:      key_q.k1    <= cfg_wdata_i;
        REG_KEY2:      key_q.k2    <= cfg_wdata_i;
        REG_KEY3:      key_q.k3    <= cfg_wdata_i;
        REG_EDGE_BITS: edge_bits_q <= cfg_wdata_i[EDGE_BITS_W-1:0];
        REG_BKT_BITS:  bkt_bits_q  <= cfg_wdata_i[BKT_BITS_W-1:0];
        REG_BKT_CAP:   bkt_cap_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ; // drop writes to unknown indices
      endcase
    end
  end

  // Derived static settings: clamped widths, node and bucket masks, bucket shift.
  logic [EDGE_BITS_W-1:0] eb;
  logic [EDGE_BITS_W:0]   eb_p1;
  logic [BKT_BITS_W-1:0]  xb;
  logic [EDGE_BITS_W:0]   bkt_shift;
  logic [NODE_W-1:0]      node_mask;
  logic [NODE_W-1:0]      bkt_mask;

  always_comb begin
    eb = (32'(edge_bits_q) > EDGE_BITS_MAX) ? EDGE_BITS_W'(EDGE_BITS_MAX) : edge_bits_q;
    xb = (32'(bkt_bits_q) > BUCKET_BITS_MAX) ? BKT_BITS_W'(BUCKET_BITS_MAX) : bkt_bits_q;
    eb_p1 = {1'b0, eb} + (EDGE_BITS_W+1)'(1);
    // Bucket wider than the node: take the low bits instead.
    if ((EDGE_BITS_W+1)'(xb) > eb_p1) begin
      bkt_shift = '0;
    end else begin
      bkt_shift = eb_p1 - (EDGE_BITS_W+1)'(xb);
    end
    node_mask = ~({NODE_W{1'b1}} << eb_p1);
    bkt_mask  = ~({NODE_W{1'b1}} << xb);
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid entry is full
  // --------------------------------------------------------------------------
  logic out_vld_q, out_vld_d;
  logic skid_vld_q, skid_vld_d;
  logic adv;

  assign adv        = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // --------------------------------------------------------------------------
  // Hash lanes
  // --------------------------------------------------------------------------
  logic [HASH_STAGES:0] vld_q;
  logic                 rej_q [HASH_STAGES+1];
  logic                 in_rej;
  logic [WORD_W-1:0]    msg_u, msg_v;
  logic [WORD_W-1:0]    hash_u, hash_v;

  assign in_rej = (edge_index_i >> eb) != '0;
  assign msg_u  = {{(WORD_W-EDGE_IDX_W-1){1'b0}}, edge_index_i, 1'b0};
  assign msg_v  = {{(WORD_W-EDGE_IDX_W-1){1'b0}}, edge_index_i, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[HASH_STAGES-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rej_q[0] <= in_rej;
      for (int k = 1; k <= HASH_STAGES; k++) begin
        rej_q[k] <= rej_q[k-1];
      end
    end
  end

  sgb_sip_pipe u_lane_u (
    .clk_i  (clk_i),
    .en_i   (adv),
    .key_i  (key_q),
    .msg_i  (msg_u),
    .hash_o (hash_u)
  );

  sgb_sip_pipe u_lane_v (
    .clk_i  (clk_i),
    .en_i   (adv),
    .key_i  (key_q),
    .msg_i  (msg_v),
    .hash_o (hash_v)
  );

  // --------------------------------------------------------------------------
  // Node stage: mask nodes, pick the bucket, issue the counter read next
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0] node_u, node_v, bkt_full;

  assign node_u   = hash_u[NODE_W-1:0] & node_mask;
  assign node_v   = (hash_v[NODE_W-1:0] & node_mask) | NODE_W'(1);
  assign bkt_full = (node_u >> bkt_shift) & bkt_mask;

  logic                a_vld_q, a_rej_q;
  logic [NODE_W-1:0]   a_u_q, a_v_q;
  logic [BKT_ID_W-1:0] a_bkt_q;
  logic [AW-1:0]       a_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= vld_q[HASH_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rej_q  <= rej_q[HASH_STAGES];
      a_u_q    <= node_u;
      a_v_q    <= node_v;
      a_bkt_q  <= bkt_full[BKT_ID_W-1:0];
      a_addr_q <= bkt_full[AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Counter memory: read on entry to the update stage, write back on exit
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] fill_mem [NB];
  logic [NB-1:0]    fill_vld_q;
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             fwd_q;
  logic [CNT_W-1:0] fwd_val_q;

  logic                b_vld_q, b_rej_q;
  logic [NODE_W-1:0]   b_u_q, b_v_q;
  logic [BKT_ID_W-1:0] b_bkt_q;
  logic [AW-1:0]       b_addr_q;

  logic [CNT_W-1:0] b_cur, b_next;
  logic             b_wr;

  // Count seen by this edge: forwarded from the edge just ahead, else the
  // memory word, else zero for a bucket untouched since reset.
  always_comb begin
    if (fwd_q) begin
      b_cur = fwd_val_q;
    end else if (rd_vld_q) begin
      b_cur = rd_data_q;
    end else begin
      b_cur = '0;
    end
    // Hold a saturated counter.
    b_next = (&b_cur) ? b_cur : b_cur + CNT_W'(1);
    b_wr   = adv & b_vld_q & ~b_rej_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      fill_mem[b_addr_q] <= b_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= fill_mem[a_addr_q];
      rd_vld_q  <= fill_vld_q[a_addr_q];
      fwd_q     <= b_wr & (b_addr_q == a_addr_q);
      fwd_val_q <= b_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
    end else if (b_wr) begin
      fill_vld_q[b_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_rej_q  <= a_rej_q;
      b_u_q    <= a_u_q;
      b_v_q    <= a_v_q;
      b_bkt_q  <= a_bkt_q;
      b_addr_q <= a_addr_q;
    end
  end

  res_t b_res;

  always_comb begin
    b_res.node_u     = b_u_q;
    b_res.node_v     = b_v_q;
    b_res.bucket_id  = b_bkt_q;
    b_res.slot_index = b_rej_q ? '0 : b_cur;
    b_res.stored     = ~b_rej_q & (b_cur < bkt_cap_q);
    b_res.distinct   = b_u_q != b_v_q;
    b_res.rejected   = b_rej_q;
  end

  // --------------------------------------------------------------------------
  // Output register and skid entry
  // --------------------------------------------------------------------------
  res_t out_q, skid_q;
  logic push, take;
  logic load_out_new, load_out_skid, load_skid;

  assign push = adv & b_vld_q;
  assign take = out_vld_q & ~out_stall_i;

  always_comb begin
    out_vld_d     = out_vld_q;
    skid_vld_d    = skid_vld_q;
    load_out_new  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_vld_q) begin
      // Pipeline is held; refill the output from the skid once it drains.
      if (take) begin
        load_out_skid = 1'b1;
        skid_vld_d    = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        load_out_new = 1'b1;
        out_vld_d    = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_new) begin
      out_q <= b_res;
    end else if (load_out_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= b_res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign node_u_o     = out_q.node_u;
  assign node_v_o     = out_q.node_v;
  assign bucket_id_o  = out_q.bucket_id;
  assign slot_index_o = out_q.slot_index;
  assign stored_o     = out_q.stored;
  assign distinct_o   = out_q.distinct;
  assign rejected_o   = out_q.rejected;

endmodule

[test/siphash_edge_generator_bucketer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SipHash edge generator and bucketer testbench
// Feeds edge indices through the valid/stall input channel under a series of
// key, edge_bits, bucket_bits and capacity settings, and checks every result
// against an in-bench SipHash-2-4 predictor with its own bucket fill counters.
// ----------------------------------------------------------------------------
module siphash_edge_generator_bucketer_core_tb;
  import sgb_pkg::*;

  // Clamps that the block applies to over-range edge_bits and bucket_bits
  localparam int unsigned EDGE_BITS_CAP = 30;
  localparam int unsigned BKT_BITS_CAP  = 5;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Allow a margin for stray results at the end
  localparam int unsigned TAIL_CYCLES  = 40;

  // Register index that decodes to nothing; a write there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [WORD_W-1:0]    FIN_CONST = 64'h0000_0000_0000_00ff;

  typedef struct packed {
    logic [NODE_W-1:0]   node_u;
    logic [NODE_W-1:0]   node_v;
    logic [BKT_ID_W-1:0] bucket;
    logic [CNT_W-1:0]    slot;
    logic                stored;
    logic                distinct;
    logic                rejected;
  } edge_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } sip_lane_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [WORD_W-1:0]     cfg_wdata = '0;

  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [EDGE_IDX_W-1:0] edge_index = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NODE_W-1:0]     node_u;
  logic [NODE_W-1:0]     node_v;
  logic [BKT_ID_W-1:0]   bucket_id;
  logic [CNT_W-1:0]      slot_index;
  logic                  stored;
  logic                  distinct;
  logic                  rejected;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  siphash_edge_generator_bucketer_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .edge_index_i (edge_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .node_u_o     (node_u),
    .node_v_o     (node_v),
    .bucket_id_o  (bucket_id),
    .slot_index_o (slot_index),
    .stored_o     (stored),
    .distinct_o   (distinct),
    .rejected_o   (rejected)
  );

  // --------------------------------------------------------------------------
  // Mirror of the configuration and of the bucket fill counters
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0]      key_m [4];
  logic [EDGE_BITS_W-1:0] edge_bits_m = EDGE_BITS_RST;
  logic [BKT_BITS_W-1:0]  bkt_bits_m  = BKT_BITS_RST;
  logic [CNT_W-1:0]       bkt_cap_m   = BKT_CAP_RST;
  logic [CNT_W-1:0]       fill_m [32];

  // Stimulus and bookkeeping
  logic [EDGE_IDX_W-1:0] pending_edges_q [$];
  edge_res_t             edge_results_q  [$];
  int unsigned edges_queued = 0;
  int unsigned edges_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned n_bad        = 0;
  int unsigned n_stored     = 0;
  int unsigned n_rejected   = 0;
  int unsigned n_same_nodes = 0;
  int unsigned n_settings   = 1;
  int unsigned cycle_cnt    = 0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  logic        hold_req     = 1'b0;
  logic        hold_used    = 1'b0;
  int unsigned hold_left    = 0;
  logic        in_took      = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x};
    return dbl[127-n -: 64];
  endfunction

  function automatic sip_lane_t sip_round_st(input sip_lane_t s);
    s.a += s.b;
    s.c += s.d;
    s.b = rol64(s.b, 13) ^ s.a;
    s.d = rol64(s.d, 16) ^ s.c;
    s.a = rol64(s.a, 32);
    s.c += s.b;
    s.a += s.d;
    s.b = rol64(s.b, 17) ^ s.c;
    s.d = rol64(s.d, 21) ^ s.a;
    s.c = rol64(s.c, 32);
    return s;
  endfunction

  // Two compression rounds, message fold-in, four finalisation rounds
  function automatic logic [WORD_W-1:0] sip24_hash(input logic [WORD_W-1:0] msg);
    sip_lane_t s;
    s.a = key_m[0];
    s.b = key_m[1];
    s.c = key_m[2];
    s.d = key_m[3] ^ msg;
    for (int r = 0; r < 6; r++) begin
      if (r == 2) begin
        s.a ^= msg;
        s.c ^= FIN_CONST;
      end
      s = sip_round_st(s);
    end
    return s.a ^ s.b ^ s.c ^ s.d;
  endfunction

  // Work out the result of one accepted edge and advance its bucket counter
  function automatic edge_res_t predict_edge(input logic [EDGE_IDX_W-1:0] idx_in);
    int unsigned       ebc;
    int unsigned       xbc;
    int unsigned       sh;
    logic [WORD_W-1:0] idx;
    logic [WORD_W-1:0] nmask;
    logic [WORD_W-1:0] u;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] bkt;
    edge_res_t         r;
    ebc   = (edge_bits_m > EDGE_BITS_CAP) ? EDGE_BITS_CAP : edge_bits_m;
    xbc   = (bkt_bits_m > BKT_BITS_CAP) ? BKT_BITS_CAP : bkt_bits_m;
    idx   = {34'd0, idx_in};
    nmask = (64'd1 << (ebc + 1)) - 64'd1;
    u     = sip24_hash(idx << 1) & nmask;
    v     = (sip24_hash((idx << 1) | 64'd1) & nmask) | 64'd1;
    // A bucket field wider than the node falls back to the node's low bits
    sh    = (xbc > ebc + 1) ? 0 : ebc + 1 - xbc;
    bkt   = (u >> sh) & ((64'd1 << xbc) - 64'd1);
    r.node_u   = u[NODE_W-1:0];
    r.node_v   = v[NODE_W-1:0];
    r.bucket   = bkt[BKT_ID_W-1:0];
    r.distinct = (u != v);
    r.rejected = (idx >= (64'd1 << ebc));
    r.slot     = '0;
    r.stored   = 1'b0;
    // Rejected edges leave every counter alone; a full counter sticks
    if (!r.rejected) begin
      r.slot = fill_m[r.bucket];
      if (r.slot != '1) fill_m[r.bucket] = r.slot + 1'b1;
      r.stored = (r.slot < bkt_cap_m);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_KEY0:      key_m[0]    = data;
      REG_KEY1:      key_m[1]    = data;
      REG_KEY2:      key_m[2]    = data;
      REG_KEY3:      key_m[3]    = data;
      REG_EDGE_BITS: edge_bits_m = data[EDGE_BITS_W-1:0];
      REG_BKT_BITS:  bkt_bits_m  = data[BKT_BITS_W-1:0];
      REG_BKT_CAP:   bkt_cap_m   = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Write every register; narrow ones carry junk in their upper bits
  task automatic load_config(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                             input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                             input logic [EDGE_BITS_W-1:0] eb,
                             input logic [BKT_BITS_W-1:0] xb,
                             input logic [CNT_W-1:0] cap);
    logic [WORD_W-1:0] junk;
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    junk = {$urandom, $urandom};
    write_reg(REG_EDGE_BITS, {junk[63:EDGE_BITS_W], eb});
    junk = {$urandom, $urandom};
    write_reg(REG_BKT_BITS, {junk[63:BKT_BITS_W], xb});
    junk = {$urandom, $urandom};
    write_reg(REG_BKT_CAP, {junk[63:CNT_W], cap});
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_edge(input logic [EDGE_IDX_W-1:0] x);
    pending_edges_q.push_back(x);
    edges_queued++;
  endtask

  // Mostly in-range indices, with the range ends, the first rejected index
  // and full-width values (rejected whenever edge_bits is small)
  function automatic logic [EDGE_IDX_W-1:0] pick_index();
    int unsigned       ebc;
    int unsigned       r;
    logic [WORD_W-1:0] lim;
    logic [WORD_W-1:0] tmp;
    ebc = (edge_bits_m > EDGE_BITS_CAP) ? EDGE_BITS_CAP : edge_bits_m;
    lim = 64'd1 << ebc;
    r   = $urandom_range(0, 99);
    tmp = {$urandom, $urandom};
    if (r < 6)                               tmp = lim - 64'd1;
    else if (r < 9)                          tmp = '0;
    else if (r < 14 && lim < 64'h4000_0000)  tmp = lim;
    else if (r < 85)                         tmp = tmp & (lim - 64'd1);
    return tmp[EDGE_IDX_W-1:0];
  endfunction

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_edge(pick_index());
  endtask

  // Hold until every queued edge has been taken and every result checked
  task automatic wait_idle();
    while (edges_taken != edges_queued || edge_results_q.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender: present the next pending edge once the current one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (pending_edges_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid   <= 1'b1;
        edge_index <= pending_edges_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off to fill the block up
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    edge_res_t got;
    edge_res_t want;
    in_took <= rst_ni && in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      edge_results_q.push_back(predict_edge(edge_index));
      edges_taken++;
    end
    if (rst_ni && out_valid && !out_stall) begin
      got.node_u   = node_u;
      got.node_v   = node_v;
      got.bucket   = bucket_id;
      got.slot     = slot_index;
      got.stored   = stored;
      got.distinct = distinct;
      got.rejected = rejected;
      results_seen++;
      if (got.stored)    n_stored++;
      if (got.rejected)  n_rejected++;
      if (!got.distinct) n_same_nodes++;
      if (edge_results_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] result %0d arrived with nothing outstanding", $realtime,
                   results_seen);
      end else begin
        want = edge_results_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] result %0d differs: exp u=%h v=%h bkt=%0d slot=%h st=%b ",
                     $realtime, results_seen, want.node_u, want.node_v, want.bucket,
                     want.slot, want.stored,
                     "dis=%b rej=%b / got u=%h v=%h bkt=%0d slot=%h st=%b dis=%b rej=%b",
                     want.distinct, want.rejected, got.node_u, got.node_v, got.bucket,
                     got.slot, got.stored, got.distinct, got.rejected);
        end
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               edge_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (key_m[i]) key_m[i] = '0;
    foreach (fill_m[i]) fill_m[i] = '0;
    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;

    // Sender idles lightly, receiver stalls heavily
    snd_idle_pct = 29;
    rcv_idle_pct = 45;

    // Reset defaults: zero keys, edge_bits set to 20, 32 buckets
    queue_edge(30'd0);
    queue_edge(30'd1);
    queue_edge(30'h000F_FFFF);
    queue_edge(30'h0010_0000);
    queue_edge(30'h3FFF_FFFF);
    queue_random(300);
    wait_idle();

    // Tiny graph, four buckets, capacity soon exhausted
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd4, 3'd2, 32'd3);
    queue_edge(30'd0);
    queue_edge(30'd15);
    queue_edge(30'd16);
    queue_edge(30'h3FFF_FFFF);
    queue_random(250);
    wait_idle();

    // Bucket field wider than the node; nothing ever stored
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd3, 3'd5, 32'd0);
    queue_edge(30'd0);
    queue_edge(30'd7);
    queue_edge(30'd8);
    queue_random(150);
    wait_idle();

    // Zero edge bits: one-bit nodes, so the endpoints often coincide;
    // bucket_bits over range is clamped
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd0, 3'd7, 32'd1);
    queue_edge(30'd0);
    queue_edge(30'd1);
    queue_edge(30'd2);
    queue_random(100);
    wait_idle();

    // Swap the idling roles
    snd_idle_pct = 45;
    rcv_idle_pct = 29;

    // All-ones keys, edge_bits over range, widest capacity
    load_config('1, '1, '1, '1, 5'd31, 3'd6, 32'hFFFF_FFFF);
    queue_edge(30'd0);
    queue_edge(30'h3FFF_FFFF);
    queue_edge(30'h1555_5555);
    queue_edge(30'h2AAA_AAAA);
    queue_random(300);
    wait_idle();

    // Drop a write to the unused index, then one bucket only
    write_reg(REG_SPARE, '1);
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd12, 3'd0, 32'd100);
    queue_edge(30'd0);
    queue_edge(30'h0000_0FFF);
    queue_edge(30'h0000_1000);
    queue_random(300);
    wait_idle();

    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd20, 3'd3,
                32'h8000_0000);
    queue_random(250);
    wait_idle();

    // Full rate on both sides, with one long receiver hold-off
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd16, 3'd4, 32'd500);
    queue_random(350);
    hold_req = 1'b1;
    wait_idle();

    load_config(rand_word(), rand_word(), rand_word(), rand_word(), 5'd30, 3'd1, 32'd1000);
    queue_edge(30'd0);
    queue_edge(30'h3FFF_FFFF);
    queue_random(150);
    wait_idle();

    // Let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d results for %0d edges across %0d register settings.",
             results_seen, edges_taken, n_settings);
    $display("Of these %0d were stored, %0d rejected, %0d had equal endpoints.",
             n_stored, n_rejected, n_same_nodes);
    if (n_bad == 0 && edge_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/sgb_pkg.sv
rtl/core/sgb_sip_pipe.sv
rtl/core/siphash_edge_generator_bucketer_core.sv
test/siphash_edge_generator_bucketer_core_tb.sv
